@@ sv/khdh_pkg.sv @@
`default_nettype none
package khdh_pkg;

  localparam int MAX_KEYS = 10;
  localparam int HIST_BINS = 512;
  localparam int HIST_DEPTH = MAX_KEYS * HIST_BINS;
  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int KEY_W = 4;
  localparam int BIN_W = 9;
  localparam int COUNT_W = 16;
  localparam int HOLD_W = 32;
  localparam int PLAY_W = 40;
  localparam int SEEN_W = 2;
  localparam logic [SEEN_W-1:0] SKIP_FRAMES = SEEN_W'(3);
  localparam logic [KEY_W-1:0] KEY_COUNT_RST = KEY_W'(7);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};
  localparam logic [PLAY_W-1:0] PLAY_MAX = {PLAY_W{1'b1}};

  // Register index of the configuration port.
  localparam logic REG_KEY_COUNT = 1'b0;

  // Input commands and result kinds.
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_RDWAIT
  } state_t;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_READ,
    HOP_INCR
  } hist_op_t;

  typedef struct packed {
    hist_op_t             op;
    logic [HIST_AW-1:0]   addr;
  } hist_req_t;

  typedef struct packed {
    logic                 clearing;
    logic [COUNT_W-1:0]   count;
  } hist_rsp_t;

endpackage
`default_nettype wire

@@ sv/khdh_hist.sv @@
`default_nettype none
module khdh_hist (
  input  wire                  clk,
  input  wire                  rst_n,
  input  khdh_pkg::hist_req_t  req,
  output khdh_pkg::hist_rsp_t  rsp
);

  logic [khdh_pkg::COUNT_W-1:0] mem [0:khdh_pkg::HIST_DEPTH-1];

  logic [khdh_pkg::COUNT_W-1:0] rdata_r;
  logic                         clearing_r;
  logic                         clearing_nxt;
  logic [khdh_pkg::HIST_AW-1:0] clr_cnt_r;
  logic [khdh_pkg::HIST_AW-1:0] clr_cnt_nxt;
  logic                         pend_r;
  logic                         pend_nxt;
  logic [khdh_pkg::HIST_AW-1:0] pend_addr_r;

  logic                         we;
  logic [khdh_pkg::HIST_AW-1:0] waddr;
  logic [khdh_pkg::COUNT_W-1:0] wdata;
  logic                         re;

  assign re = (req.op != khdh_pkg::HOP_NONE);

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == khdh_pkg::HIST_AW'(khdh_pkg::HIST_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    pend_nxt = (req.op == khdh_pkg::HOP_INCR);
  end

  // The increment is written back in the cycle after the read; a full bin stays full.
  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_r;
    wdata = rdata_r + 1'b1;
    if (clearing_r) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else if (pend_r && (rdata_r != khdh_pkg::COUNT_MAX)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      pend_r     <= 1'b0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= req.addr;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rsp.clearing = clearing_r;
  assign rsp.count    = rdata_r;

endmodule
`default_nettype wire

@@ sv/key_hold_duration_histogram.sv @@
// Key hold duration histogram.
// An item enters on the command channel (start, busy): a frame sample
// (in_cmd = 0) with a timestamp and a key mask, or a read (in_cmd = 1) of one
// histogram bin. It is taken at a clock edge with start high and busy low.
// Results leave on the out_ ports for one cycle each, marked by out_valid;
// out_last flags the final result of an item. The receiver cannot stall, so
// results are never held back.
// A read keeps busy high for one cycle; its bin count is on the out_ ports in
// the cycle after that, in which the block can already take the next item.
// A processed frame walks all key lanes one per cycle and stops in the wait
// state for the histogram read-modify-write of every released key, keeping
// busy high until the walk ends; a skipped or non-advancing frame leaves busy
// low. Each release result passes from the scan state that reads its bin
// through the wait state into the result register.
// After reset the histogram memory is cleared one entry a cycle, with busy
// high until the pass ends. Register key_count (APB, address 0) may be written
// at any time the block is idle; it resets to 7.
`default_nettype none
module key_hold_duration_histogram (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_cmd,
  input  wire  [31:0] in_frame_time,
  input  wire  [9:0]  in_key_mask,
  input  wire  [3:0]  in_read_key,
  input  wire  [8:0]  in_read_bin,
  output logic        out_valid,
  output logic        out_kind,
  output logic [3:0]  out_key_index,
  output logic [31:0] out_hold_ms,
  output logic [39:0] out_play_time_ms,
  output logic [15:0] out_bin_count,
  output logic        out_last,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NK = khdh_pkg::MAX_KEYS;
  localparam int KW = khdh_pkg::KEY_W;
  localparam int HW = khdh_pkg::HOLD_W;
  localparam int PW = khdh_pkg::PLAY_W;
  localparam int AW = khdh_pkg::HIST_AW;

  khdh_pkg::state_t state_r, state_nxt;

  logic [KW-1:0]                    key_count_r;
  logic [31:0]                      prev_r, prev_nxt;
  logic [khdh_pkg::SEEN_W-1:0]      seen_r, seen_nxt;
  logic [NK-1:0]                    held_r, held_nxt;
  logic [PW-1:0]                    play_r, play_nxt;
  logic [HW-1:0]                    accum_r [NK];
  logic [HW-1:0]                    accum_nxt [NK];
  logic [HW-1:0]                    delta_r, delta_nxt;
  logic [NK-1:0]                    rel_r, rel_nxt;
  logic [NK-1:0]                    act_r, act_nxt;
  logic [NK-1:0]                    lane_r, lane_nxt;
  logic [KW-1:0]                    k_r, k_nxt;
  logic [HW-1:0]                    h_r, h_nxt;
  logic [KW-1:0]                    rk_r, rk_nxt;
  logic                             oor_r, oor_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [3:0]  out_key_r, out_key_nxt;
  logic [31:0] out_hold_r, out_hold_nxt;
  logic [39:0] out_play_r, out_play_nxt;
  logic [15:0] out_count_r, out_count_nxt;
  logic        out_last_r, out_last_nxt;

  khdh_pkg::hist_req_t hist_req;
  khdh_pkg::hist_rsp_t hist_rsp;

  logic          accept;
  logic          skip;
  logic [32:0]   delta_wide;
  logic          delta_pos;
  logic [KW-1:0] nl;
  logic [NK-1:0] lane_now;
  logic [NK-1:0] later;
  logic          last_rel;
  logic          scan_rel;
  logic          at_end;
  logic [HW:0]   accum_sum;
  logic [HW-1:0] accum_sat;
  logic [PW:0]   play_sum;
  logic [khdh_pkg::BIN_W-1:0] bin;

  khdh_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .rsp   (hist_rsp)
  );

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= khdh_pkg::KEY_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == khdh_pkg::REG_KEY_COUNT)) begin
      key_count_r <= pwdata[KW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == khdh_pkg::REG_KEY_COUNT) begin
      prdata = {{(32-KW){1'b0}}, key_count_r};
    end
  end

  // Shared datapath terms.
  assign busy      = (state_r != khdh_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign skip      = (seen_r < khdh_pkg::SKIP_FRAMES);
  assign delta_wide = {in_frame_time[31], in_frame_time} - {prev_r[31], prev_r};
  assign delta_pos = !delta_wide[32] && (delta_wide != '0);
  assign nl        = (key_count_r > KW'(NK)) ? KW'(NK) : key_count_r;
  assign play_sum  = {1'b0, play_r} + {{(PW+1-32){1'b0}}, delta_wide[31:0]};
  assign accum_sum = {1'b0, accum_r[k_r]} + {1'b0, delta_r};
  assign accum_sat = accum_sum[HW] ? khdh_pkg::HOLD_MAX : accum_sum[HW-1:0];
  assign scan_rel  = lane_r[k_r] && act_r[k_r] && rel_r[k_r];
  assign at_end    = (k_r == KW'(NK - 1));
  assign bin       = (accum_sat >= HW'(khdh_pkg::HIST_BINS - 1))
                     ? khdh_pkg::BIN_W'(khdh_pkg::HIST_BINS - 1)
                     : accum_sat[khdh_pkg::BIN_W-1:0];

  always_comb begin
    for (int i = 0; i < NK; i++) begin
      lane_now[i] = (KW'(i) < nl);
      later[i]    = (KW'(i) > k_r);
    end
  end

  assign last_rel = ((rel_r & later) == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      khdh_pkg::S_CLEAR: begin
        if (!hist_rsp.clearing) state_nxt = khdh_pkg::S_IDLE;
      end
      khdh_pkg::S_IDLE: begin
        if (accept) begin
          if (in_cmd == khdh_pkg::CMD_READ) begin
            state_nxt = khdh_pkg::S_RDWAIT;
          end else if (!skip && delta_pos) begin
            state_nxt = khdh_pkg::S_SCAN;
          end
        end
      end
      khdh_pkg::S_SCAN: begin
        if (scan_rel) begin
          state_nxt = khdh_pkg::S_WAIT;
        end else if (at_end) begin
          state_nxt = khdh_pkg::S_IDLE;
        end
      end
      khdh_pkg::S_WAIT: begin
        state_nxt = at_end ? khdh_pkg::S_IDLE : khdh_pkg::S_SCAN;
      end
      khdh_pkg::S_RDWAIT: state_nxt = khdh_pkg::S_IDLE;
      default: state_nxt = khdh_pkg::S_IDLE;
    endcase
  end

  // Datapath next values and histogram requests.
  always_comb begin
    prev_nxt  = prev_r;
    seen_nxt  = seen_r;
    held_nxt  = held_r;
    play_nxt  = play_r;
    delta_nxt = delta_r;
    rel_nxt   = rel_r;
    act_nxt   = act_r;
    lane_nxt  = lane_r;
    k_nxt     = k_r;
    h_nxt     = h_r;
    rk_nxt    = rk_r;
    oor_nxt   = oor_r;
    for (int i = 0; i < NK; i++) begin
      accum_nxt[i] = accum_r[i];
    end
    hist_req.op   = khdh_pkg::HOP_NONE;
    hist_req.addr = '0;

    case (state_r)
      khdh_pkg::S_IDLE: begin
        if (accept && (in_cmd == khdh_pkg::CMD_READ)) begin
          rk_nxt  = in_read_key;
          oor_nxt = !((in_read_key < KW'(NK)) &&
                      ({1'b0, in_read_bin} < (khdh_pkg::BIN_W + 1)'(khdh_pkg::HIST_BINS)));
          if (!oor_nxt) begin
            hist_req.op   = khdh_pkg::HOP_READ;
            hist_req.addr = AW'(in_read_key) * AW'(khdh_pkg::HIST_BINS) + AW'(in_read_bin);
          end
        end else if (accept) begin
          prev_nxt = in_frame_time;
          if (skip) begin
            seen_nxt = seen_r + 1'b1;
          end else if (delta_pos) begin
            play_nxt  = play_sum[PW] ? khdh_pkg::PLAY_MAX : play_sum[PW-1:0];
            delta_nxt = delta_wide[31:0];
            rel_nxt   = held_r & ~in_key_mask & lane_now;
            act_nxt   = held_r & lane_now;
            lane_nxt  = lane_now;
            held_nxt  = in_key_mask & lane_now;
            k_nxt     = '0;
          end
        end
      end
      khdh_pkg::S_SCAN: begin
        if (!lane_r[k_r]) begin
          accum_nxt[k_r] = '0;
        end else if (act_r[k_r]) begin
          accum_nxt[k_r] = scan_rel ? '0 : accum_sat;
        end
        if (scan_rel) begin
          h_nxt         = accum_sat;
          hist_req.op   = khdh_pkg::HOP_INCR;
          hist_req.addr = AW'(k_r) * AW'(khdh_pkg::HIST_BINS) + AW'(bin);
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      khdh_pkg::S_WAIT: k_nxt = k_r + 1'b1;
      default: ;
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_kind_nxt  = khdh_pkg::KIND_RELEASE;
    out_key_nxt   = '0;
    out_hold_nxt  = '0;
    out_play_nxt  = '0;
    out_count_nxt = '0;
    out_last_nxt  = 1'b0;
    case (state_r)
      khdh_pkg::S_WAIT: begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = k_r;
        out_hold_nxt  = h_r;
        out_play_nxt  = play_r;
        out_last_nxt  = last_rel;
      end
      khdh_pkg::S_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = khdh_pkg::KIND_COUNT;
        out_key_nxt   = rk_r;
        out_count_nxt = oor_r ? '0 : hist_rsp.count;
        out_last_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= khdh_pkg::S_CLEAR;
      prev_r      <= '0;
      seen_r      <= '0;
      held_r      <= '0;
      play_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NK; i++) begin
        accum_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      seen_r      <= seen_nxt;
      held_r      <= held_nxt;
      play_r      <= play_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NK; i++) begin
        accum_r[i] <= accum_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    delta_r     <= delta_nxt;
    rel_r       <= rel_nxt;
    act_r       <= act_nxt;
    lane_r      <= lane_nxt;
    h_r         <= h_nxt;
    rk_r        <= rk_nxt;
    oor_r       <= oor_nxt;
    out_kind_r  <= out_kind_nxt;
    out_key_r   <= out_key_nxt;
    out_hold_r  <= out_hold_nxt;
    out_play_r  <= out_play_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_key_index    = out_key_r;
  assign out_hold_ms      = out_hold_r;
  assign out_play_time_ms = out_play_r;
  assign out_bin_count    = out_count_r;
  assign out_last         = out_last_r;

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == khdh_pkg::S_WAIT ||
                     $past(state_r) == khdh_pkg::S_RDWAIT))
    else $error("result without a completed histogram access");

  a_release_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == khdh_pkg::KIND_RELEASE)) |-> (out_hold_r != '0))
    else $error("release with zero hold time");

  a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    hist_rsp.clearing |-> (busy && hist_req.op == khdh_pkg::HOP_NONE))
    else $error("histogram access during clearing pass");

  a_incr_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_req.op == khdh_pkg::HOP_INCR) |=>
      ##1 (out_valid_r && (out_kind_r == khdh_pkg::KIND_RELEASE)))
    else $error("histogram increment without release item");

endmodule
`default_nettype wire

@@ tb/tb_key_hold_duration_histogram.sv @@
`timescale 1ns / 100ps

module tb_key_hold_duration_histogram;

  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic        cmd;
    logic [31:0] ftime;
    logic [9:0]  mask;
    logic [3:0]  rkey;
    logic [8:0]  rbin;
  } key_item_t;

  typedef struct {
    logic                          kind;
    logic [khdh_pkg::KEY_W-1:0]    key;
    logic [khdh_pkg::HOLD_W-1:0]   hold;
    logic [khdh_pkg::PLAY_W-1:0]   play;
    logic [khdh_pkg::COUNT_W-1:0]  count;
    logic                          last;
  } key_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = 1'b0;
  logic [31:0] in_frame_time = '0;
  logic [9:0]  in_key_mask = '0;
  logic [3:0]  in_read_key = '0;
  logic [8:0]  in_read_bin = '0;
  logic        out_valid;
  logic        out_kind;
  logic [3:0]  out_key_index;
  logic [31:0] out_hold_ms;
  logic [39:0] out_play_time_ms;
  logic [15:0] out_bin_count;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow state of the block, advanced at every accepted item.
  logic [khdh_pkg::KEY_W-1:0]   lanes_cfg = khdh_pkg::KEY_COUNT_RST;
  logic [31:0]                  prev_time_model = '0;
  logic [khdh_pkg::SEEN_W-1:0]  seen_model = '0;
  logic [9:0]                   held_model = '0;
  logic [khdh_pkg::HOLD_W-1:0]  accum_model [khdh_pkg::MAX_KEYS] = '{default: '0};
  logic [khdh_pkg::PLAY_W-1:0]  play_model = '0;
  logic [khdh_pkg::COUNT_W-1:0] hist_model [khdh_pkg::HIST_DEPTH] = '{default: '0};

  key_item_t   item_q [$];
  key_result_t due_q [$];
  key_item_t   cur_item;
  key_result_t due;
  int          send_idle_pct = 0;
  int          mism_count = 0;
  int          frames_taken = 0;
  int          reads_taken = 0;
  int          results_checked = 0;
  int          stall_cycles = 0;
  logic [31:0] gen_time = 32'd1000;
  logic [9:0]  gen_mask = '0;
  logic [3:0]  mid_lanes;

  key_hold_duration_histogram i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_frame_time    (in_frame_time),
    .in_key_mask      (in_key_mask),
    .in_read_key      (in_read_key),
    .in_read_bin      (in_read_bin),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_key_index    (out_key_index),
    .out_hold_ms      (out_hold_ms),
    .out_play_time_ms (out_play_time_ms),
    .out_bin_count    (out_bin_count),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  // Works out the results one item causes and updates the shadow state.
  function automatic void track_item(input key_item_t it);
    longint          delta;
    longint unsigned sum;
    int              lanes_n;
    int              nrel;
    int unsigned     bin;
    key_result_t     r;
    nrel = 0;
    if (it.cmd == khdh_pkg::CMD_READ) begin
      r = '{khdh_pkg::KIND_COUNT, it.rkey, '0, '0, '0, 1'b1};
      if (int'(it.rkey) < khdh_pkg::MAX_KEYS && int'(it.rbin) < khdh_pkg::HIST_BINS) begin
        r.count = hist_model[int'(it.rkey) * khdh_pkg::HIST_BINS + int'(it.rbin)];
      end
      due_q.insert(due_q.size(), r);
      return;
    end
    if (seen_model < khdh_pkg::SKIP_FRAMES) begin
      seen_model++;
      prev_time_model = it.ftime;
      return;
    end
    delta = longint'($signed(it.ftime)) - longint'($signed(prev_time_model));
    prev_time_model = it.ftime;
    if (delta <= 0) return;
    sum = play_model + delta;
    play_model = (sum > khdh_pkg::PLAY_MAX) ? khdh_pkg::PLAY_MAX : 40'(sum);
    lanes_n = (lanes_cfg > khdh_pkg::MAX_KEYS) ? khdh_pkg::MAX_KEYS : int'(lanes_cfg);
    for (int k = 0; k < khdh_pkg::MAX_KEYS; k++) begin
      if (k >= lanes_n) begin
        accum_model[k] = '0;
      end else if (held_model[k]) begin
        sum = accum_model[k] + delta;
        accum_model[k] = (sum > khdh_pkg::HOLD_MAX) ? khdh_pkg::HOLD_MAX : 32'(sum);
        if (!it.mask[k]) begin
          bin = (accum_model[k] >= khdh_pkg::HIST_BINS - 1) ? khdh_pkg::HIST_BINS - 1
                                                              : accum_model[k];
          if (hist_model[k * khdh_pkg::HIST_BINS + bin] != khdh_pkg::COUNT_MAX) begin
            hist_model[k * khdh_pkg::HIST_BINS + bin]++;
          end
          r = '{khdh_pkg::KIND_RELEASE, 4'(k), accum_model[k], play_model, '0, 1'b0};
          due_q.insert(due_q.size(), r);
          nrel++;
          accum_model[k] = '0;
        end
      end
    end
    held_model = it.mask & 10'((1 << lanes_n) - 1);
    if (nrel > 0) due_q[$].last = 1'b1;
  endfunction

  task automatic push_frame(input logic [31:0] t, input logic [9:0] m);
    key_item_t it;
    it = '{khdh_pkg::CMD_FRAME, t, m, 4'($urandom()), 9'($urandom())};
    item_q.insert(item_q.size(), it);
  endtask

  task automatic push_read(input logic [3:0] k, input logic [8:0] b);
    key_item_t it;
    it = '{khdh_pkg::CMD_READ, $urandom(), 10'($urandom()), k, b};
    item_q.insert(item_q.size(), it);
  endtask

  // Mostly coherent key activity with small time steps, mixed with bin reads,
  // time jumps and frames whose time does not advance.
  task automatic fill_random(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        push_read(pick < 17 ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 15)),
                  pick < 12 ? 9'($urandom_range(0, 40)) : 9'($urandom_range(0, 511)));
      end else if (pick < 26) begin
        gen_time = $urandom();
        gen_mask = 10'($urandom());
        push_frame(gen_time, gen_mask);
      end else if (pick < 32) begin
        gen_time = gen_time - $urandom_range(0, 50);
        push_frame(gen_time, gen_mask);
      end else begin
        gen_time = gen_time + (pick >= 95 ? $urandom_range(300, 900) : $urandom_range(1, 40));
        gen_mask ^= 10'(1 << $urandom_range(0, 9));
        if ($urandom_range(0, 2) == 0) gen_mask ^= 10'(1 << $urandom_range(0, 9));
        push_frame(gen_time, gen_mask);
      end
    end
  endtask

  // Returns once every item is taken, every result is in and the block is idle.
  task automatic wait_idle();
    do @(negedge clk); while (item_q.size() != 0 || start || due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_key_count(input logic [3:0] kc);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * int'(khdh_pkg::REG_KEY_COUNT));
    pwdata <= 32'(kc);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    lanes_cfg = kc;
  endtask

  always @(posedge clk) begin
    if (start && !busy) begin
      track_item(cur_item);
      if (cur_item.cmd == khdh_pkg::CMD_READ) reads_taken++;
      else frames_taken++;
    end
    if (!(start && busy)) begin
      if (rst_n && item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_item = item_q.pop_front();
        start <= 1'b1;
        in_cmd <= cur_item.cmd;
        in_frame_time <= cur_item.ftime;
        in_key_mask <= cur_item.mask;
        in_read_key <= cur_item.rkey;
        in_read_bin <= cur_item.rbin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_checked++;
      if (due_q.size() == 0) begin
        mism_count++;
        if (mism_count <= MAX_REPORTS) begin
          $display("unexpected result: kind %0d key %0d hold %0d play %0d count %0d last %0d",
                   out_kind, out_key_index, out_hold_ms, out_play_time_ms,
                   out_bin_count, out_last);
        end
      end else begin
        due = due_q.pop_front();
        if (out_kind !== due.kind || out_key_index !== due.key || out_hold_ms !== due.hold ||
            out_play_time_ms !== due.play || out_bin_count !== due.count ||
            out_last !== due.last) begin
          mism_count++;
          if (mism_count <= MAX_REPORTS) begin
            $display("mismatch: expected kind %0d key %0d hold %0d play %0d count %0d last %0d",
                     due.kind, due.key, due.hold, due.play, due.count, due.last);
            $display("          got      kind %0d key %0d hold %0d play %0d count %0d last %0d",
                     out_kind, out_key_index, out_hold_ms, out_play_time_ms,
                     out_bin_count, out_last);
          end
        end
      end
    end
  end

  // The limit covers the histogram clearing pass after reset with room to spare.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    write_key_count(4'd10);
    send_idle_pct = 16;
    // The first three frames only record their time.
    push_frame(32'd100, 10'h3FF);
    push_frame(32'd5, 10'h000);
    push_frame(32'd50, 10'h155);
    push_frame(32'd60, 10'h3FF);
    // Equal and earlier times are ignored but still kept.
    push_frame(32'd60, 10'h000);
    push_frame(32'd40, 10'h000);
    // All ten keys released at once.
    push_frame(32'd45, 10'h000);
    push_read(4'd0, 9'd5);
    push_frame(32'd46, 10'h3FF);
    // A long hold lands in the last bin.
    push_frame(32'd646, 10'h2AA);
    push_read(4'd2, 9'd511);
    push_read(4'd9, 9'd511);
    push_read(4'd10, 9'd0);
    push_read(4'd15, 9'd511);
    push_frame(32'h7FFF_FFFF, 10'h3FF);
    push_frame(32'h8000_0000, 10'h000);
    // Largest possible step: every accumulated hold saturates.
    push_frame(32'h7FFF_FFFF, 10'h000);
    push_read(4'd1, 9'd511);
    push_read(4'd0, 9'd0);
    wait_idle();

    write_key_count(4'd4);
    fill_random(45);
    wait_idle();
    write_key_count(4'd1);
    fill_random(20);
    wait_idle();

    send_idle_pct = 53;
    write_key_count(4'd15);
    fill_random(45);
    wait_idle();
    write_key_count(4'd0);
    fill_random(20);
    wait_idle();

    send_idle_pct = 0;
    mid_lanes = 4'($urandom_range(2, 9));
    write_key_count(mid_lanes);
    fill_random(30);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d frames and %0d bin reads with key counts 10, 4, 1, 15, 0 and %0d,",
             frames_taken, reads_taken, mid_lanes);
    $display("including hold time saturation; %0d results checked, %0d mismatches.",
             results_checked, mism_count);
    if (mism_count == 0 && due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
